FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the digit locator.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/bcdl_pkg.sv
// Package of the bar code digit locator: sizes, band limits, state type and digit table.
// No dependencies; imported by bar_code_digit_locator_unit.
`default_nettype none

package bcdl_pkg;

	// Field widths.
	localparam int CoordW = 9;
	localparam int DigitW = 4;
	localparam int CountW = 8;
	localparam int PosW   = 7;
	localparam int LocW   = 8;

	// Default sizes and the number of digits actually held in the table.
	localparam int WindowDigitsDef = 5;
	localparam int TableDigitsDef  = 111;
	localparam int TableStored     = 109;

	// Row limit; a segment yields a digit only when its centre y exceeds it.
	localparam logic [CoordW-1:0] RowLimit = 9'd120;

	// Width bands (signed width) and centre-x bands.
	localparam logic signed [CoordW:0] WidthBand1 = 10'sd90;
	localparam logic signed [CoordW:0] WidthBand2 = 10'sd170;
	localparam logic signed [CoordW:0] WidthBand3 = 10'sd270;
	localparam logic [CoordW-1:0] CxNarrow1 = 9'd110;
	localparam logic [CoordW-1:0] CxNarrow2 = 9'd200;
	localparam logic [CoordW-1:0] CxNarrow3 = 9'd290;
	localparam logic [CoordW-1:0] CxMid1    = 9'd170;
	localparam logic [CoordW-1:0] CxMid2    = 9'd250;
	localparam logic [CoordW-1:0] CxWide1   = 9'd220;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} bcdl_state_t;

	// Decimal digits of pi after the point.
	localparam logic [DigitW-1:0] PiTable [0:TableStored-1] = '{
		4'd1, 4'd4, 4'd1, 4'd5, 4'd9, 4'd2, 4'd6, 4'd5, 4'd3, 4'd5,
		4'd8, 4'd9, 4'd7, 4'd9, 4'd3, 4'd2, 4'd3, 4'd8, 4'd4, 4'd6,
		4'd2, 4'd6, 4'd4, 4'd3, 4'd3, 4'd8, 4'd3, 4'd2, 4'd7, 4'd9,
		4'd5, 4'd0, 4'd2, 4'd8, 4'd8, 4'd4, 4'd1, 4'd9, 4'd7, 4'd1,
		4'd6, 4'd9, 4'd3, 4'd9, 4'd9, 4'd3, 4'd7, 4'd5, 4'd1, 4'd0,
		4'd5, 4'd8, 4'd2, 4'd0, 4'd9, 4'd7, 4'd4, 4'd9, 4'd4, 4'd4,
		4'd5, 4'd9, 4'd2, 4'd3, 4'd0, 4'd7, 4'd8, 4'd1, 4'd6, 4'd4,
		4'd0, 4'd6, 4'd2, 4'd8, 4'd6, 4'd2, 4'd0, 4'd8, 4'd9, 4'd9,
		4'd8, 4'd6, 4'd2, 4'd8, 4'd0, 4'd3, 4'd4, 4'd8, 4'd2, 4'd5,
		4'd3, 4'd4, 4'd2, 4'd1, 4'd1, 4'd7, 4'd0, 4'd6, 4'd7, 4'd9,
		4'd8, 4'd2, 4'd1, 4'd4, 4'd8, 4'd0, 4'd8, 4'd6, 4'd5
	};

	// Table lookup; positions past the stored digits read as zero.
	function automatic logic [DigitW-1:0] pi_digit(input logic [PosW-1:0] idx);
		logic [DigitW-1:0] d;
		d = '0;
		if (int'(idx) < TableStored) begin
			d = PiTable[idx];
		end
		return d;
	endfunction

	// Digit class of one segment from its signed width and centre x.
	function automatic logic [DigitW-1:0] classify(
		input logic signed [CoordW:0] width,
		input logic [CoordW-1:0] cx
	);
		logic [DigitW-1:0] d;
		if (width < WidthBand1) begin
			if (cx < CxNarrow1)      d = 4'd1;
			else if (cx < CxNarrow2) d = 4'd2;
			else if (cx < CxNarrow3) d = 4'd3;
			else                     d = 4'd4;
		end else if (width < WidthBand2) begin
			if (cx < CxMid1)      d = 4'd5;
			else if (cx < CxMid2) d = 4'd6;
			else                  d = 4'd7;
		end else if (width < WidthBand3) begin
			if (cx < CxWide1) d = 4'd8;
			else              d = 4'd9;
		end else begin
			d = 4'd0;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bar_code_digit_locator_unit.sv
// Top level of the bar code digit locator: digit classing, window, serial table search.
// Depends on bcdl_pkg and assert_macros.svh.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | left_x, right_x, center_x, center_y, last_segment
// out     | output    | out_valid / out_stall| location, found, digit_count
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (position_offset)
//
// A segment is taken only in the idle state. When it completes a full window and no match is
// latched yet, the shared window comparator tests one table position per cycle, positions 0 to
// min(TABLE_DIGITS,109) - WINDOW_DIGITS (104 by default), stopping at a hit.
// A last segment then goes on to load the output register, which waits while an earlier
// result is still stalled there. in_stall is high throughout.
// Reset clears the frame state and the offset; no clearing pass is needed.
`default_nettype none

module bar_code_digit_locator_unit #(
	parameter int WINDOW_DIGITS = bcdl_pkg::WindowDigitsDef,
	parameter int TABLE_DIGITS  = bcdl_pkg::TableDigitsDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bcdl_pkg::PosW-1:0]     cfg_data,
	// Segment channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bcdl_pkg::CoordW-1:0]   left_x,
	input  wire logic [bcdl_pkg::CoordW-1:0]   right_x,
	input  wire logic [bcdl_pkg::CoordW-1:0]   center_x,
	input  wire logic [bcdl_pkg::CoordW-1:0]   center_y,
	input  wire logic                          last_segment,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [bcdl_pkg::LocW-1:0]   location,
	output logic                               found,
	output logic [bcdl_pkg::CountW-1:0]        digit_count
);
	import bcdl_pkg::*;

	// Searchable table length and the last window start position.
	localparam int SearchLen = (TABLE_DIGITS < TableStored) ? TABLE_DIGITS : TableStored;
	localparam bit SearchOk  = (WINDOW_DIGITS <= SearchLen);
	localparam int LastPosI  = SearchOk ? (SearchLen - WINDOW_DIGITS) : 0;
	localparam logic [PosW-1:0] LastPos = PosW'(LastPosI);
	localparam logic [CountW-1:0] WindowCount = CountW'(WINDOW_DIGITS);

	bcdl_state_t state_q, state_d;

	logic [PosW-1:0]   offset_q;
	logic [DigitW-1:0] window_q [WINDOW_DIGITS];
	logic [CountW-1:0] digits_seen_q;
	logic              match_found_q;
	logic [PosW-1:0]   match_pos_q;
	logic [PosW-1:0]   pos_q;
	logic              last_q;

	logic              out_valid_q;
	logic [LocW-1:0]   location_q;
	logic              found_q;
	logic [CountW-1:0] count_q;

	logic              in_acc;
	logic              row_hit;
	logic [DigitW-1:0] new_digit;
	logic [CountW-1:0] count_next;
	logic              search_start;
	logic              hit;
	logic              search_end;
	logic              out_free;
	logic              out_load;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// Classing of the incoming segment and the search start decision.
	assign in_acc     = in_valid && !in_stall;
	assign row_hit    = (center_y > RowLimit);
	assign new_digit  = classify(signed'({1'b0, right_x}) - signed'({1'b0, left_x}), center_x);
	assign count_next = (digits_seen_q == '1) ? digits_seen_q : digits_seen_q + 1'b1;
	assign search_start = in_acc && row_hit && !match_found_q && SearchOk
		&& (count_next >= WindowCount);

	// Shared window comparator against the table at the current position.
	always_comb begin
		hit = 1'b1;
		for (int k = 0; k < WINDOW_DIGITS; k++) begin
			if (pi_digit(pos_q + PosW'(k)) != window_q[k]) begin
				hit = 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (search_start) state_d = ST_SEARCH;
					else if (last_segment) state_d = ST_EMIT;
				end
			end
			ST_SEARCH: begin
				if (hit || pos_q == LastPos) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall   = 1'b1;
		search_end = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SEARCH: search_end = hit || (pos_q == LastPos);
			ST_EMIT:   out_load = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame state: window, digit count, latched match and search position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_DIGITS; k++) window_q[k] <= '0;
			digits_seen_q <= '0;
			match_found_q <= 1'b0;
			match_pos_q   <= '0;
			pos_q         <= '0;
			last_q        <= 1'b0;
		end else if (out_load) begin
			for (int k = 0; k < WINDOW_DIGITS; k++) window_q[k] <= '0;
			digits_seen_q <= '0;
			match_found_q <= 1'b0;
			match_pos_q   <= '0;
			last_q        <= 1'b0;
		end else if (in_acc) begin
			last_q <= last_segment;
			pos_q  <= '0;
			if (row_hit) begin
				for (int k = 0; k + 1 < WINDOW_DIGITS; k++) window_q[k] <= window_q[k + 1];
				window_q[WINDOW_DIGITS - 1] <= new_digit;
				digits_seen_q <= count_next;
			end
		end else if (state_q == ST_SEARCH) begin
			if (hit) begin
				match_found_q <= 1'b1;
				match_pos_q   <= pos_q;
			end else if (!search_end) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Output register; it frees once its transaction completes.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			location_q <= match_found_q ? ({1'b0, match_pos_q} - {1'b0, offset_q})
				: ~{1'b0, offset_q};
			found_q    <= match_found_q;
			count_q    <= digits_seen_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign location    = signed'(location_q);
	assign found       = found_q;
	assign digit_count = count_q;

	// Checks on the sequencer.
	`include "assert_macros.svh"

	`ASSERT_SAME(a_no_search_after_match, clk, arst_n, state_q == ST_SEARCH, !match_found_q)
	`ASSERT_SAME(a_pos_in_range, clk, arst_n, state_q == ST_SEARCH, pos_q <= LastPos)
	`ASSERT_NEXT(a_clear_on_emit, clk, arst_n, out_load, digits_seen_q == '0 && out_valid_q)
	`ASSERT_SAME(a_result_from_emit, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_EMIT))

endmodule

`default_nettype wire
